// ===== hw/rtl/pplsb_pkg.sv =====
`default_nettype none

package pplsb_pkg;

    // Dimension range: width and height run from 1 to 2**DIM_BITS - 1.
    localparam int DIM_BITS = 16;
    // Parsed numbers saturate at 2**DIM_BITS, so one extra bit holds them.
    localparam int NUM_W    = DIM_BITS + 1;
    localparam int PROD_W   = 2 * DIM_BITS;
    // floor(w * h * 3 / 8) never needs more than this.
    localparam int LIM_W    = PROD_W - 1;

    localparam logic [NUM_W-1:0] DIM_CAP = NUM_W'(1) << DIM_BITS;
    localparam logic [NUM_W-1:0] MAXVAL  = NUM_W'(255);

    // Result queue.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Parser phases.
    localparam logic [3:0] PH_MAGIC      = 4'd0;
    localparam logic [3:0] PH_MAGIC_TAIL = 4'd1;
    localparam logic [3:0] PH_COMMENT_W  = 4'd2;
    localparam logic [3:0] PH_PEEK_W     = 4'd3;
    localparam logic [3:0] PH_SKIP_W     = 4'd4;
    localparam logic [3:0] PH_NUM_W      = 4'd5;
    localparam logic [3:0] PH_SKIP_H     = 4'd6;
    localparam logic [3:0] PH_NUM_H      = 4'd7;
    localparam logic [3:0] PH_COMMENT_M  = 4'd8;
    localparam logic [3:0] PH_PEEK_M     = 4'd9;
    localparam logic [3:0] PH_SKIP_M     = 4'd10;
    localparam logic [3:0] PH_NUM_M      = 4'd11;
    localparam logic [3:0] PH_BODY       = 4'd12;
    localparam logic [3:0] PH_DONE       = 4'd13;

    // Magic progress codes.
    localparam logic [1:0] MG_NONE = 2'd0;
    localparam logic [1:0] MG_P    = 2'd1;
    localparam logic [1:0] MG_P6   = 2'd2;

    // Result kinds.
    localparam logic [2:0] K_CHAR   = 3'd0;
    localparam logic [2:0] K_FOUND  = 3'd1;
    localparam logic [2:0] K_LIMIT  = 3'd2;
    localparam logic [2:0] K_MAGIC  = 3'd3;
    localparam logic [2:0] K_HEADER = 3'd4;
    localparam logic [2:0] K_PROPS  = 3'd5;
    localparam logic [2:0] K_EARLY  = 3'd6;

    // Characters of interest.
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] MSG_END  = 8'hFF;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_val;
        logic       last;
    } result_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_dig(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_sign(input logic [7:0] b);
        return (b == CH_PLUS) || (b == CH_MINUS);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ppm_lsb_message_extractor.sv =====
`default_nettype none

// Recovers a message hidden in the least significant bits of a binary PPM
// (P6) file that arrives one byte per request on the slave side. The header
// (magic, width, height, maxval, with comment lines allowed before width
// and before maxval) is checked, then the LSB of each pixel byte is packed
// MSB first into message bytes, each of which is sent as a char result.
// Every file ends in exactly one status result (message end found, limit
// of floor(w*h*3/8) bytes reached, bad magic, malformed header, bad
// properties, or early end); bytes after the status are dropped until the
// byte flagged with s_tlast, which returns the block to its start for the
// next file. The parser takes one byte in every cycle that s_tready is high:
// its step is a single combinational pass from the current byte and state
// into the state registers and into a four-entry result queue. s_tready
// holds while at least two queue entries are free, so with m_tready high
// the block runs at one byte per cycle; a byte that yields two results (a
// char followed by its status) has them sent one after the other.

module ppm_lsb_message_extractor (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Slave side: file bytes.
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // end_of_file
    // Master side: results.
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] message_char
    output logic [2:0]      m_tuser,   // [2:0] result_kind
    output logic            m_tlast    // last_result
);

    // Parser state.
    logic [3:0]                      phase_reg, phase_next;
    logic [1:0]                      magic_reg, magic_next;
    logic [pplsb_pkg::NUM_W-1:0]     width_reg, width_next;
    logic [pplsb_pkg::NUM_W-1:0]     height_reg, height_next;
    logic [pplsb_pkg::NUM_W-1:0]     accum_reg, accum_next;
    logic                            neg_reg, neg_next;
    logic                            seen_reg, seen_next;
    logic [7:0]                      collect_reg, collect_next;
    logic [2:0]                      bitcnt_reg, bitcnt_next;
    logic [pplsb_pkg::LIM_W-1:0]     done_reg, done_next;
    logic [pplsb_pkg::LIM_W-1:0]     limit_reg, limit_next;

    // The dimensions are settled at least two bytes before the header ends
    // (maxval needs a digit and the closing whitespace), so the product is
    // computed in a register of its own ahead of the property check.
    logic [pplsb_pkg::PROD_W-1:0]    prod_reg;
    logic [pplsb_pkg::PROD_W+1:0]    prod_x3;
    logic [pplsb_pkg::LIM_W-1:0]     limit_calc;

    logic                            in_accept;
    logic [7:0]                      b;
    logic                            b_ws, b_dig, b_sign, b_start;
    logic [pplsb_pkg::NUM_W-1:0]     digit_val;
    logic [pplsb_pkg::NUM_W+3:0]     accum_wide;
    logic [pplsb_pkg::NUM_W-1:0]     accum_sat;
    logic [pplsb_pkg::NUM_W-1:0]     num_val;
    logic [7:0]                      collect_shift;
    logic [pplsb_pkg::LIM_W-1:0]     done_inc;
    logic                            props_bad;

    // What this byte produces: an optional char, then an optional status.
    logic                            emit_char;
    logic                            emit_stat;
    logic [2:0]                      stat_kind;
    logic [1:0]                      res_cnt;
    pplsb_pkg::result_t              res0, res1;

    // Result queue.
    pplsb_pkg::result_t              queue_reg [pplsb_pkg::QDEPTH];
    logic [pplsb_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [pplsb_pkg::QPTR_W:0]      count_reg;
    logic                            out_pop;

    assign in_accept = s_tvalid && s_tready;
    assign b         = s_tdata;
    assign b_ws      = pplsb_pkg::is_ws(b);
    assign b_dig     = pplsb_pkg::is_dig(b);
    assign b_sign    = pplsb_pkg::is_sign(b);
    assign b_start   = b_dig || b_sign;
    assign digit_val = {{(pplsb_pkg::NUM_W-4){1'b0}}, b[3:0]};

    // accum * 10 + digit, saturated at the dimension cap.
    assign accum_wide = ({3'b000, accum_reg, 1'b0} + {1'b0, accum_reg, 3'b000})
                        + {4'b0000, digit_val};
    assign accum_sat  = (accum_wide > {4'b0000, pplsb_pkg::DIM_CAP}) ?
                        pplsb_pkg::DIM_CAP : accum_wide[pplsb_pkg::NUM_W-1:0];
    // A negative number counts as zero.
    assign num_val    = neg_reg ? '0 : accum_reg;

    assign prod_x3    = {2'b00, prod_reg} + {1'b0, prod_reg, 1'b0};
    assign limit_calc = prod_x3[pplsb_pkg::PROD_W+1:3];

    assign collect_shift = {collect_reg[6:0], b[0]};
    assign done_inc      = done_reg + pplsb_pkg::LIM_W'(1);

    // Width and height must be nonzero and below the cap (a saturated value
    // sits exactly on the cap); maxval must be 255.
    assign props_bad = (width_reg == '0) || (height_reg == '0) ||
                       width_reg[pplsb_pkg::DIM_BITS] ||
                       height_reg[pplsb_pkg::DIM_BITS] ||
                       (num_val != pplsb_pkg::MAXVAL);

    always_ff @(posedge aclk) begin
        prod_reg <= pplsb_pkg::PROD_W'(width_reg[pplsb_pkg::DIM_BITS-1:0]) *
                    pplsb_pkg::PROD_W'(height_reg[pplsb_pkg::DIM_BITS-1:0]);
    end

    always_comb begin
        phase_next   = phase_reg;
        magic_next   = magic_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        accum_next   = accum_reg;
        neg_next     = neg_reg;
        seen_next    = seen_reg;
        collect_next = collect_reg;
        bitcnt_next  = bitcnt_reg;
        done_next    = done_reg;
        limit_next   = limit_reg;
        emit_char    = 1'b0;
        emit_stat    = 1'b0;
        stat_kind    = pplsb_pkg::K_CHAR;

        case (phase_reg)
            pplsb_pkg::PH_MAGIC: begin
                if (magic_reg == pplsb_pkg::MG_NONE) begin
                    if (b == pplsb_pkg::CH_P) begin
                        magic_next = pplsb_pkg::MG_P;
                    end else if (!b_ws) begin
                        emit_stat = 1'b1;
                        stat_kind = pplsb_pkg::K_MAGIC;
                    end
                end else if (magic_reg == pplsb_pkg::MG_P) begin
                    if (b == pplsb_pkg::CH_6) begin
                        magic_next = pplsb_pkg::MG_P6;
                    end else begin
                        emit_stat = 1'b1;
                        stat_kind = pplsb_pkg::K_MAGIC;
                    end
                end else if (magic_reg == pplsb_pkg::MG_P6 && b_ws) begin
                    phase_next = pplsb_pkg::PH_MAGIC_TAIL;
                end else begin
                    emit_stat = 1'b1;
                    stat_kind = pplsb_pkg::K_MAGIC;
                end
            end
            pplsb_pkg::PH_MAGIC_TAIL, pplsb_pkg::PH_PEEK_W, pplsb_pkg::PH_SKIP_W: begin
                // A comment may open anywhere in the whitespace after the magic or right
                // after another comment, but not after spaces that follow a comment.
                if (b == pplsb_pkg::CH_HASH && phase_reg != pplsb_pkg::PH_SKIP_W) begin
                    phase_next = pplsb_pkg::PH_COMMENT_W;
                end else if (b_ws) begin
                    if (phase_reg == pplsb_pkg::PH_PEEK_W) begin
                        phase_next = pplsb_pkg::PH_SKIP_W;
                    end
                end else if (b_start) begin
                    neg_next   = (b == pplsb_pkg::CH_MINUS);
                    seen_next  = b_dig;
                    accum_next = b_dig ? digit_val : '0;
                    phase_next = pplsb_pkg::PH_NUM_W;
                end else begin
                    emit_stat = 1'b1;
                    stat_kind = pplsb_pkg::K_HEADER;
                end
            end
            pplsb_pkg::PH_COMMENT_W: begin
                if (b == pplsb_pkg::CH_LF) begin
                    phase_next = pplsb_pkg::PH_PEEK_W;
                end
            end
            pplsb_pkg::PH_NUM_W: begin
                if (b_dig) begin
                    accum_next = accum_sat;
                    seen_next  = 1'b1;
                end else if (!seen_reg) begin
                    emit_stat = 1'b1;
                    stat_kind = pplsb_pkg::K_HEADER;
                end else begin
                    width_next = num_val;
                    if (b_ws) begin
                        phase_next = pplsb_pkg::PH_SKIP_H;
                    end else if (b_sign) begin
                        neg_next   = (b == pplsb_pkg::CH_MINUS);
                        seen_next  = 1'b0;
                        accum_next = '0;
                        phase_next = pplsb_pkg::PH_NUM_H;
                    end else begin
                        emit_stat = 1'b1;
                        stat_kind = pplsb_pkg::K_HEADER;
                    end
                end
            end
            pplsb_pkg::PH_SKIP_H: begin
                if (b_ws) begin
                    phase_next = phase_reg;
                end else if (b_start) begin
                    neg_next   = (b == pplsb_pkg::CH_MINUS);
                    seen_next  = b_dig;
                    accum_next = b_dig ? digit_val : '0;
                    phase_next = pplsb_pkg::PH_NUM_H;
                end else begin
                    emit_stat = 1'b1;
                    stat_kind = pplsb_pkg::K_HEADER;
                end
            end
            pplsb_pkg::PH_NUM_H: begin
                if (b_dig) begin
                    accum_next = accum_sat;
                    seen_next  = 1'b1;
                end else if (!seen_reg) begin
                    emit_stat = 1'b1;
                    stat_kind = pplsb_pkg::K_HEADER;
                end else begin
                    height_next = num_val;
                    if (b == pplsb_pkg::CH_HASH) begin
                        phase_next = pplsb_pkg::PH_COMMENT_M;
                    end else if (b_ws) begin
                        phase_next = pplsb_pkg::PH_SKIP_M;
                    end else if (b_sign) begin
                        neg_next   = (b == pplsb_pkg::CH_MINUS);
                        seen_next  = 1'b0;
                        accum_next = '0;
                        phase_next = pplsb_pkg::PH_NUM_M;
                    end else begin
                        emit_stat = 1'b1;
                        stat_kind = pplsb_pkg::K_HEADER;
                    end
                end
            end
            pplsb_pkg::PH_COMMENT_M: begin
                if (b == pplsb_pkg::CH_LF) begin
                    phase_next = pplsb_pkg::PH_PEEK_M;
                end
            end
            pplsb_pkg::PH_PEEK_M, pplsb_pkg::PH_SKIP_M: begin
                if (b == pplsb_pkg::CH_HASH && phase_reg == pplsb_pkg::PH_PEEK_M) begin
                    phase_next = pplsb_pkg::PH_COMMENT_M;
                end else if (b_ws) begin
                    phase_next = pplsb_pkg::PH_SKIP_M;
                end else if (b_start) begin
                    neg_next   = (b == pplsb_pkg::CH_MINUS);
                    seen_next  = b_dig;
                    accum_next = b_dig ? digit_val : '0;
                    phase_next = pplsb_pkg::PH_NUM_M;
                end else begin
                    emit_stat = 1'b1;
                    stat_kind = pplsb_pkg::K_HEADER;
                end
            end
            pplsb_pkg::PH_NUM_M: begin
                if (b_dig) begin
                    accum_next = accum_sat;
                    seen_next  = 1'b1;
                end else if (!seen_reg || !b_ws) begin
                    emit_stat = 1'b1;
                    stat_kind = pplsb_pkg::K_HEADER;
                end else if (props_bad) begin
                    emit_stat = 1'b1;
                    stat_kind = pplsb_pkg::K_PROPS;
                end else begin
                    // The single whitespace after maxval closes the header.
                    limit_next   = limit_calc;
                    done_next    = '0;
                    collect_next = '0;
                    bitcnt_next  = '0;
                    if (limit_calc == '0) begin
                        emit_stat = 1'b1;
                        stat_kind = pplsb_pkg::K_LIMIT;
                    end else begin
                        phase_next = pplsb_pkg::PH_BODY;
                    end
                end
            end
            pplsb_pkg::PH_BODY: begin
                collect_next = collect_shift;
                if (bitcnt_reg != 3'd7) begin
                    bitcnt_next = bitcnt_reg + 3'd1;
                end else begin
                    bitcnt_next = '0;
                    if (collect_shift == pplsb_pkg::MSG_END) begin
                        emit_stat = 1'b1;
                        stat_kind = pplsb_pkg::K_FOUND;
                    end else begin
                        emit_char = 1'b1;
                        done_next = done_inc;
                        // The counter never passes the limit, so equality
                        // is the point where it is reached.
                        if (done_inc == limit_reg) begin
                            emit_stat = 1'b1;
                            stat_kind = pplsb_pkg::K_LIMIT;
                        end
                    end
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase

        if (emit_stat) begin
            phase_next = pplsb_pkg::PH_DONE;
        end

        if (s_tlast) begin
            // The file ends: give a status unless one is already out, then
            // return to the start for the next file.
            if (phase_reg != pplsb_pkg::PH_DONE && !emit_stat) begin
                emit_stat = 1'b1;
                if (phase_next == pplsb_pkg::PH_MAGIC &&
                    magic_next != pplsb_pkg::MG_P6) begin
                    stat_kind = pplsb_pkg::K_MAGIC;
                end else if (phase_next == pplsb_pkg::PH_BODY) begin
                    stat_kind = pplsb_pkg::K_EARLY;
                end else begin
                    stat_kind = pplsb_pkg::K_HEADER;
                end
            end
            phase_next   = pplsb_pkg::PH_MAGIC;
            magic_next   = pplsb_pkg::MG_NONE;
            width_next   = '0;
            height_next  = '0;
            accum_next   = '0;
            neg_next     = 1'b0;
            seen_next    = 1'b0;
            collect_next = '0;
            bitcnt_next  = '0;
            done_next    = '0;
            limit_next   = '0;
        end
    end

    // Pack the results of this byte into at most two queue entries.
    always_comb begin
        res1.kind     = stat_kind;
        res1.char_val = '0;
        res1.last     = 1'b1;
        if (emit_char) begin
            res0.kind     = pplsb_pkg::K_CHAR;
            res0.char_val = collect_shift;
            res0.last     = !emit_stat;
        end else begin
            res0 = res1;
        end
        res_cnt = {1'b0, emit_char} + {1'b0, emit_stat};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= pplsb_pkg::PH_MAGIC;
            magic_reg   <= pplsb_pkg::MG_NONE;
            width_reg   <= '0;
            height_reg  <= '0;
            accum_reg   <= '0;
            neg_reg     <= 1'b0;
            seen_reg    <= 1'b0;
            collect_reg <= '0;
            bitcnt_reg  <= '0;
            done_reg    <= '0;
            limit_reg   <= '0;
        end else if (in_accept) begin
            phase_reg   <= phase_next;
            magic_reg   <= magic_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            accum_reg   <= accum_next;
            neg_reg     <= neg_next;
            seen_reg    <= seen_next;
            collect_reg <= collect_next;
            bitcnt_reg  <= bitcnt_next;
            done_reg    <= done_next;
            limit_reg   <= limit_next;
        end
    end

    // Result queue: up to two writes per cycle, one read. No byte is taken
    // while reset is held.
    assign out_pop  = m_tvalid && m_tready;
    assign s_tready = aresetn &&
                      (count_reg <= (pplsb_pkg::QPTR_W+1)'(pplsb_pkg::QDEPTH - 2));
    assign m_tvalid = (count_reg != '0);
    assign m_tuser  = queue_reg[rd_ptr_reg].kind;
    assign m_tdata  = queue_reg[rd_ptr_reg].char_val;
    assign m_tlast  = queue_reg[rd_ptr_reg].last;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            if (res_cnt != 2'd0) begin
                queue_reg[wr_ptr_reg] <= res0;
            end
            if (res_cnt == 2'd2) begin
                queue_reg[wr_ptr_reg + pplsb_pkg::QPTR_W'(1)] <= res1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (in_accept) begin
                wr_ptr_reg <= wr_ptr_reg + pplsb_pkg::QPTR_W'(res_cnt);
            end
            if (out_pop) begin
                rd_ptr_reg <= rd_ptr_reg + pplsb_pkg::QPTR_W'(1);
            end
            count_reg <= count_reg
                         + (in_accept ? (pplsb_pkg::QPTR_W+1)'(res_cnt) : '0)
                         - (pplsb_pkg::QPTR_W+1)'(out_pop);
        end
    end

endmodule

`default_nettype wire
